// ===== src/q2e_pkg.sv =====
// shared types, widths and constants for the quaternion to euler angle core
// no dependencies
`default_nettype none
package q2e_pkg;

    localparam int CORDIC_STAGES       = 16;
    localparam int ANGLE_FRACTION_BITS = 13;

    localparam int TABLE_LEN = 24;
    localparam int N_STG     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int Q_W   = 16;   // quaternion component
    localparam int P_W   = 32;   // component product
    localparam int T_W   = 35;   // terms t0..t4 at scale 2^28
    localparam int T2_W  = 30;   // clamped pitch term
    localparam int V_W   = 58;   // radicand at scale 2^56
    localparam int SQ_STEPS = 29;
    localparam int R_W   = SQ_STEPS;      // root width
    localparam int REM_W = R_W + 2;       // remainder width
    localparam int C_W   = 38;   // cordic vector width
    localparam int A_W   = 36;   // angle width at scale 2^30
    localparam int O_W   = 16;   // output angle width

    localparam logic signed [T_W-1:0] ONE_T  = T_W'(64'sd268435456);
    localparam logic [V_W-1:0]        ONE_SQ = V_W'(64'd1) << 56;
    localparam logic signed [A_W-1:0] PI_A   = A_W'(64'sd3373259426);

    localparam logic signed [A_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        A_W'(64'sd843314857), A_W'(64'sd497837829), A_W'(64'sd263043837),
        A_W'(64'sd133525159), A_W'(64'sd67021688),  A_W'(64'sd33543516),
        A_W'(64'sd16775851),  A_W'(64'sd8388437),   A_W'(64'sd4194283),
        A_W'(64'sd2097149),   A_W'(64'sd1048576),   A_W'(64'sd524288),
        A_W'(64'sd262144),    A_W'(64'sd131072),    A_W'(64'sd65536),
        A_W'(64'sd32768),     A_W'(64'sd16384),     A_W'(64'sd8192),
        A_W'(64'sd4096),      A_W'(64'sd2048),      A_W'(64'sd1024),
        A_W'(64'sd512),       A_W'(64'sd256),       A_W'(64'sd128)
    };

    typedef logic signed [Q_W-1:0] t_comp;
    typedef logic signed [T_W-1:0] t_term;
    typedef logic signed [C_W-1:0] t_cval;
    typedef logic signed [O_W-1:0] t_angle;
    typedef logic [V_W-1:0]        t_rad;
    typedef logic [R_W-1:0]        t_root;

    typedef struct packed {
        t_term t0;
        t_term t1;
        t_term t3;
        t_term t4;
        logic signed [T2_W-1:0] t2;
    } t_terms;

endpackage
`default_nettype wire

// ===== src/q2e_if.sv =====
// request channels for quaternion input and euler angle output
// depends on q2e_pkg
`default_nettype none
interface q2e_in_if;
    logic               valid;
    logic               ready;
    q2e_pkg::t_comp     q_w;
    q2e_pkg::t_comp     q_x;
    q2e_pkg::t_comp     q_y;
    q2e_pkg::t_comp     q_z;
    modport source (output valid, q_w, q_x, q_y, q_z, input ready);
    modport sink   (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface q2e_out_if;
    logic               valid;
    logic               ready;
    q2e_pkg::t_angle    pitch;
    q2e_pkg::t_angle    roll;
    q2e_pkg::t_angle    yaw;
    modport source (output valid, pitch, roll, yaw, input ready);
    modport sink   (input valid, pitch, roll, yaw, output ready);
endinterface
`default_nettype wire

// ===== src/q2e_terms.sv =====
// four-stage front end: products, rotation terms, clamp and square, radicand
// depends on q2e_pkg
`default_nettype none
module q2e_terms (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire q2e_pkg::t_comp  i_w,
    input  wire q2e_pkg::t_comp  i_x,
    input  wire q2e_pkg::t_comp  i_y,
    input  wire q2e_pkg::t_comp  i_z,
    output q2e_pkg::t_terms      o_terms,
    output q2e_pkg::t_rad        o_v
);
    import q2e_pkg::*;

    logic signed [P_W-1:0] r_yy, r_zz, r_xy, r_wz, r_wy, r_xz, r_yz, r_wx, r_xx;
    t_term  r_t0, r_t1, r_t2, r_t3, r_t4;
    t_terms r_s3, r_s4;
    logic [2*T2_W-1:0] r_sq;
    t_rad   r_v;
    logic signed [T2_W-1:0] n_t2c;

    always_comb begin
        if (r_t2 > ONE_T) begin
            n_t2c = T2_W'(ONE_T);
        end else if (r_t2 < -ONE_T) begin
            n_t2c = T2_W'(-ONE_T);
        end else begin
            n_t2c = T2_W'(r_t2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yy <= P_W'(i_y * i_y);
            r_zz <= P_W'(i_z * i_z);
            r_xy <= P_W'(i_x * i_y);
            r_wz <= P_W'(i_w * i_z);
            r_wy <= P_W'(i_w * i_y);
            r_xz <= P_W'(i_x * i_z);
            r_yz <= P_W'(i_y * i_z);
            r_wx <= P_W'(i_w * i_x);
            r_xx <= P_W'(i_x * i_x);

            r_t0 <= ONE_T - ((T_W'(r_yy) + T_W'(r_zz)) <<< 1);
            r_t1 <= (T_W'(r_xy) + T_W'(r_wz)) <<< 1;
            r_t2 <= (T_W'(r_wy) - T_W'(r_xz)) <<< 1;
            r_t3 <= (T_W'(r_yz) + T_W'(r_wx)) <<< 1;
            r_t4 <= ONE_T - ((T_W'(r_xx) + T_W'(r_yy)) <<< 1);

            r_s3.t0 <= r_t0;
            r_s3.t1 <= r_t1;
            r_s3.t3 <= r_t3;
            r_s3.t4 <= r_t4;
            r_s3.t2 <= n_t2c;
            r_sq    <= (2*T2_W)'(n_t2c * n_t2c);

            r_s4 <= r_s3;
            r_v  <= ONE_SQ - V_W'(r_sq);
        end
    end

    assign o_terms = r_s4;
    assign o_v     = r_v;
endmodule
`default_nettype wire

// ===== src/q2e_sqrt.sv =====
// pipelined floor square root, one root bit per stage
// depends on q2e_pkg
`default_nettype none
module q2e_sqrt (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire q2e_pkg::t_rad  i_v,
    output q2e_pkg::t_root      o_root
);
    import q2e_pkg::*;

    logic [REM_W-1:0] r_rem  [SQ_STEPS];
    logic [R_W-1:0]   r_root [SQ_STEPS];
    logic [V_W-1:0]   r_v    [SQ_STEPS];

    logic [REM_W-1:0] s_rem  [SQ_STEPS+1];
    logic [R_W-1:0]   s_root [SQ_STEPS+1];
    logic [V_W-1:0]   s_v    [SQ_STEPS+1];

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_v[0]    = i_v;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        logic [REM_W+1:0] n_acc;
        logic [REM_W+1:0] n_trial;
        assign s_rem[k+1]  = r_rem[k];
        assign s_root[k+1] = r_root[k];
        assign s_v[k+1]    = r_v[k];
        assign n_acc   = {s_rem[k], s_v[k][V_W-1 -: 2]};
        assign n_trial = {2'b00, s_root[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k] <= s_v[k] << 2;
                if (n_acc >= n_trial) begin
                    r_rem[k]  <= REM_W'(n_acc - n_trial);
                    r_root[k] <= {s_root[k][R_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= REM_W'(n_acc);
                    r_root[k] <= {s_root[k][R_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = s_root[SQ_STEPS];
endmodule
`default_nettype wire

// ===== src/q2e_cordic.sv =====
// pipelined vectoring cordic arctangent with quadrant fold and output rounding
// depends on q2e_pkg
`default_nettype none
module q2e_cordic (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire q2e_pkg::t_cval  i_y,
    input  wire q2e_pkg::t_cval  i_x,
    output q2e_pkg::t_angle      o_angle
);
    import q2e_pkg::*;

    localparam int SH = 30 - ANGLE_FRACTION_BITS;
    localparam logic signed [A_W:0] RND = (A_W+1)'(1) <<< (SH - 1);
    localparam logic signed [A_W:0] MAXO = (A_W+1)'(32767);
    localparam logic signed [A_W:0] MINO = -(A_W+1)'(32768);

    t_cval r_x [N_STG+1];
    t_cval r_y [N_STG+1];
    logic signed [A_W-1:0] r_z [N_STG+1];
    t_angle r_out;
    logic signed [A_W:0] n_sum, n_sh;

    // fold the left half plane onto the right, starting at plus or minus pi
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? PI_A : -PI_A;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N_STG; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN_TAB[i];
                end
            end
        end
    end

    // round half up to the output scale, then saturate
    always_comb begin
        n_sum = (A_W+1)'(r_z[N_STG]) + RND;
        n_sh  = n_sum >>> SH;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_sh > MAXO) begin
                r_out <= O_W'(MAXO);
            end else if (n_sh < MINO) begin
                r_out <= O_W'(MINO);
            end else begin
                r_out <= O_W'(n_sh);
            end
        end
    end

    assign o_angle = r_out;
endmodule
`default_nettype wire

// ===== src/quaternion_to_euler_angles_core.sv =====
// top level: quaternion in, z-y-x euler angles out, fully pipelined
// depends on q2e_pkg, q2e_if, q2e_terms, q2e_sqrt, q2e_cordic
//
//  channel  dir  payload                     format
//  i_q      in   q_w, q_x, q_y, q_z          signed q2.14
//  o_e      out  pitch, roll, yaw            signed q3.13 radians
//
// one request enters per cycle while the output is not stalled; the pitch path runs through
// four front-end stages, 29 square root stages, the cordic stages plus fold and round
// the square root for pitch is the longest path; roll and yaw are delayed to match it
// reset clears only the valid chain; data registers carry no reset
// a stall at the output freezes the whole pipeline, so nothing is lost or repeated
`default_nettype none
module quaternion_to_euler_angles_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    q2e_in_if.sink      i_q,
    q2e_out_if.source   o_e
);
    import q2e_pkg::*;

    localparam int LAT = 35 + N_STG;

    logic   en;
    logic   r_vld [LAT];

    t_terms terms;
    t_rad   rad;
    t_root  root;
    t_angle pitch_a, roll_a, yaw_a;

    logic signed [T2_W-1:0] r_t2d [SQ_STEPS];
    t_angle r_rolld [SQ_STEPS];
    t_angle r_yawd  [SQ_STEPS];

    // whole pipe moves unless the output holds a request nobody takes
    assign en        = !o_e.valid || o_e.ready;
    assign i_q.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_q.valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    q2e_terms u_terms (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_w     (i_q.q_w),
        .i_x     (i_q.q_x),
        .i_y     (i_q.q_y),
        .i_z     (i_q.q_z),
        .o_terms (terms),
        .o_v     (rad)
    );

    q2e_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (rad),
        .o_root (root)
    );

    // roll and yaw start straight after the front end
    q2e_cordic u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (C_W'(terms.t3)),
        .i_x     (C_W'(terms.t4)),
        .o_angle (roll_a)
    );

    q2e_cordic u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (C_W'(terms.t1)),
        .i_x     (C_W'(terms.t0)),
        .o_angle (yaw_a)
    );

    // clamped pitch term waits for its cosine; roll and yaw wait for pitch
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t2d[0]   <= terms.t2;
            r_rolld[0] <= roll_a;
            r_yawd[0]  <= yaw_a;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_t2d[k]   <= r_t2d[k-1];
                r_rolld[k] <= r_rolld[k-1];
                r_yawd[k]  <= r_yawd[k-1];
            end
        end
    end

    q2e_cordic u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (C_W'(r_t2d[SQ_STEPS-1])),
        .i_x     (C_W'({1'b0, root})),
        .o_angle (pitch_a)
    );

    assign o_e.valid = r_vld[LAT-1];
    assign o_e.pitch = pitch_a;
    assign o_e.roll  = r_rolld[SQ_STEPS-1];
    assign o_e.yaw   = r_yawd[SQ_STEPS-1];

    // an accepted request always enters the valid chain
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q.valid && i_q.ready |=> r_vld[0])
        else $error("accepted request missing from pipeline");

    // a stall keeps the result at the tail of the pipe
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_e.valid && !o_e.ready |=> o_e.valid && $stable(o_e.pitch)
            && $stable(o_e.roll) && $stable(o_e.yaw) && $stable(r_vld[LAT-2]))
        else $error("stalled pipeline moved");

endmodule
`default_nettype wire
